// File: src/kbs_pkg.sv
package kbs_pkg;

    localparam int MAX_POINTS_DEF = 256;

    // wide enough for any index or count compare (MAX_POINTS <= 4096)
    localparam int CMP_W  = 16;
    localparam int CRD_W  = 32;
    localparam int TAN_W  = 33;
    localparam int BLD_W  = 38;
    localparam int SET_W  = 16;
    localparam int PAR_W  = 24;
    localparam int COEF_W = 18;
    localparam int MA_W   = 20;
    localparam int MB_W   = 38;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 64;
    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q16 = 65536;

    typedef enum logic [2:0] {
        ACT_APPEND  = 3'd0,
        ACT_SET_TB  = 3'd1,
        ACT_SET_IN  = 3'd2,
        ACT_SET_OUT = 3'd3,
        ACT_EVAL    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // one control point record, held in a single memory word
    typedef struct packed {
        logic [2:0][CRD_W-1:0] pos;
        logic [2:0][TAN_W-1:0] tin;
        logic [2:0][TAN_W-1:0] tout;
        logic [2:0][BLD_W-1:0] blend;
        logic [SET_W-1:0]      tens;
        logic [SET_W-1:0]      bias;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [4:0] {
        DA_NONE,
        DA_CAP,
        DA_NEW,
        DA_NEW0,
        DA_MOD,
        DA_CP,
        DA_CN,
        DA_BLEND,
        DA_S2,
        DA_S3,
        DA_RES,
        DA_RES_POS,
        DA_WR_PREV,
        DA_WR_NEW,
        DA_WR_IDX,
        DA_ST_RANGE,
        DA_ST_EMPTY,
        DA_PUSH
    } t_dp_act;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_CF_P,
        MS_CF_N,
        MS_S2,
        MS_S3,
        MS_BL_IN,
        MS_BL_OUT,
        MS_H00,
        MS_H10,
        MS_H01,
        MS_H11
    } t_mul_sel;

    typedef enum logic [1:0] {
        AC_HOLD,
        AC_LOAD,
        AC_ADD
    } t_acc_op;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PREV,
        RD_IDX,
        RD_LAST,
        RD_I0,
        RD_I1
    } t_rd_sel;

    typedef struct packed {
        logic      take;
        t_dp_act   act;
        t_mul_sel  mul;
        t_acc_op   acc;
        t_rd_sel   rd;
        logic      sel;
        logic [1:0] cmp;
    } t_ctl_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    has_prev;
        logic    bad_idx;
        logic    empty;
        logic    at_end;
    } t_dp_stat;

endpackage

// File: src/kbs_if.sv
interface kbs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic signed [15:0] tension_in;
    logic signed [15:0] bias_in;
    logic [23:0]        param_in;

    modport source (
        output valid, action, point_index, x_value, y_value, z_value,
               tension_in, bias_in, param_in,
        input  ready
    );
    modport sink (
        input  valid, action, point_index, x_value, y_value, z_value,
               tension_in, bias_in, param_in,
        output ready
    );
endinterface

interface kbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic [1:0]         status;

    modport source (
        output valid, x_out, y_out, z_out, status,
        input  ready
    );
    modport sink (
        input  valid, x_out, y_out, z_out, status,
        output ready
    );
endinterface

// File: src/kbs_ram.sv
module kbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kbs_dp.sv
module kbs_dp #(
    parameter int MAX_POINTS = kbs_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kbs_pkg::t_ctl_cmd   i_cmd,
    output kbs_pkg::t_dp_stat   o_stat,
    input  logic [2:0]          i_action,
    input  logic [7:0]          i_point_index,
    input  logic signed [31:0]  i_x_value,
    input  logic signed [31:0]  i_y_value,
    input  logic signed [31:0]  i_z_value,
    input  logic signed [15:0]  i_tension_in,
    input  logic signed [15:0]  i_bias_in,
    input  logic [23:0]         i_param_in,
    output logic signed [31:0]  o_x_out,
    output logic signed [31:0]  o_y_out,
    output logic signed [31:0]  o_z_out,
    output logic [1:0]          o_status
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int CMPW  = kbs_pkg::CMP_W;
    localparam int CRDW  = kbs_pkg::CRD_W;
    localparam int TANW  = kbs_pkg::TAN_W;
    localparam int BLDW  = kbs_pkg::BLD_W;
    localparam int SETW  = kbs_pkg::SET_W;
    localparam int COEFW = kbs_pkg::COEF_W;
    localparam int MAW   = kbs_pkg::MA_W;
    localparam int MBW   = kbs_pkg::MB_W;
    localparam int PRODW = kbs_pkg::PROD_W;
    localparam int ACCW  = kbs_pkg::ACC_W;
    localparam int RECW  = kbs_pkg::REC_W;

    logic [2:0]              r_act;
    logic [7:0]              r_idx;
    logic signed [CRDW-1:0]  r_v [3];
    logic signed [SETW-1:0]  r_tens;
    logic signed [SETW-1:0]  r_bias;
    logic [23:0]             r_param;
    logic [CW-1:0]           r_count;
    kbs_pkg::t_rec           r_ra;
    kbs_pkg::t_rec           r_rb;
    logic signed [COEFW-1:0] r_cp;
    logic signed [COEFW-1:0] r_cn;
    logic [15:0]             r_s2;
    logic [15:0]             r_s3;
    logic signed [PRODW-1:0] r_prod;
    logic signed [ACCW-1:0]  r_acc;
    logic signed [CRDW-1:0]  r_res [3];
    logic [1:0]              r_status;
    logic signed [CRDW-1:0]  r_ox;
    logic signed [CRDW-1:0]  r_oy;
    logic signed [CRDW-1:0]  r_oz;
    logic [1:0]              r_ostatus;

    logic [CMPW-1:0]         w_cnt;
    logic [CMPW-1:0]         w_eff;
    logic [CMPW-1:0]         w_prev;
    logic [CMPW-1:0]         w_last;
    logic [CMPW-1:0]         w_idx;
    logic [CMPW-1:0]         w_i0;
    logic [CMPW-1:0]         w_i1;
    logic                    w_restart;
    logic [AW-1:0]           w_raddr;
    logic [AW-1:0]           w_waddr;
    logic                    w_we;
    logic [RECW-1:0]         w_wdata;
    logic [RECW-1:0]         w_rdata;
    kbs_pkg::t_rec           w_rec;
    logic signed [MAW-1:0]   w_ma;
    logic signed [MBW-1:0]   w_mb;
    logic signed [MAW-1:0]   w_hs;
    logic signed [MAW-1:0]   w_hs2;
    logic signed [MAW-1:0]   w_hs3;
    logic signed [MAW-1:0]   w_h00;
    logic signed [MAW-1:0]   w_h10;
    logic signed [MAW-1:0]   w_h01;
    logic signed [MAW-1:0]   w_h11;
    logic signed [17:0]      w_onemt;
    logic signed [ACCW-1:0]  w_sum;
    logic signed [ACCW-1:0]  w_sh16;
    logic signed [CRDW-1:0]  w_sat;
    logic signed [TANW-1:0]  w_diff [3];

    // index bookkeeping; an append at index zero restarts the curve
    always_comb begin
        w_cnt     = CMPW'(r_count);
        w_idx     = CMPW'(r_idx);
        w_i0      = CMPW'(r_param[23:16]);
        w_i1      = w_i0 + CMPW'(1);
        w_restart = (r_act == kbs_pkg::ACT_APPEND) && (r_idx == '0);
        w_eff     = w_restart ? '0 : w_cnt;
        w_prev    = w_eff - CMPW'(1);
        w_last    = w_cnt - CMPW'(1);

        o_stat.action   = kbs_pkg::t_action'(r_act);
        o_stat.full     = (w_eff >= CMPW'(MAX_POINTS));
        o_stat.has_prev = (w_eff != '0);
        o_stat.bad_idx  = (w_idx >= w_cnt);
        o_stat.empty    = (w_cnt == '0);
        o_stat.at_end   = (w_i1 >= w_cnt);
    end

    always_comb begin
        case (i_cmd.rd)
            kbs_pkg::RD_PREV: w_raddr = w_prev[AW-1:0];
            kbs_pkg::RD_IDX:  w_raddr = w_idx[AW-1:0];
            kbs_pkg::RD_LAST: w_raddr = w_last[AW-1:0];
            kbs_pkg::RD_I0:   w_raddr = w_i0[AW-1:0];
            kbs_pkg::RD_I1:   w_raddr = w_i1[AW-1:0];
            default:          w_raddr = '0;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_idx[AW-1:0];
        w_wdata = r_ra;
        case (i_cmd.act)
            kbs_pkg::DA_WR_PREV: begin
                w_we    = 1'b1;
                w_waddr = w_prev[AW-1:0];
                w_wdata = r_rb;
            end
            kbs_pkg::DA_WR_NEW: begin
                w_we    = 1'b1;
                w_waddr = w_eff[AW-1:0];
            end
            kbs_pkg::DA_WR_IDX: begin
                w_we    = 1'b1;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    kbs_ram #(
        .WIDTH (RECW),
        .DEPTH (MAX_POINTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Hermite basis in Q16 from s, s^2, s^3
    always_comb begin
        w_hs  = $signed({4'b0, r_param[15:0]});
        w_hs2 = $signed({4'b0, r_s2});
        w_hs3 = $signed({4'b0, r_s3});
        w_h00 = w_hs3 + w_hs3 - (w_hs2 + w_hs2 + w_hs2) + MAW'(kbs_pkg::ONE_Q16);
        w_h10 = w_hs3 - (w_hs2 + w_hs2) + w_hs;
        w_h01 = (w_hs2 + w_hs2 + w_hs2) - (w_hs3 + w_hs3);
        w_h11 = w_hs3 - w_hs2;
    end

    always_comb begin
        w_rec   = i_cmd.sel ? r_rb : r_ra;
        w_onemt = 18'(kbs_pkg::ONE_Q14) - 18'($signed(w_rec.tens));
        w_ma    = '0;
        w_mb    = '0;
        case (i_cmd.mul)
            kbs_pkg::MS_CF_P: begin
                w_ma = MAW'(w_onemt);
                w_mb = MBW'(18'(kbs_pkg::ONE_Q14) + 18'($signed(w_rec.bias)));
            end
            kbs_pkg::MS_CF_N: begin
                w_ma = MAW'(w_onemt);
                w_mb = MBW'(18'(kbs_pkg::ONE_Q14) - 18'($signed(w_rec.bias)));
            end
            kbs_pkg::MS_S2: begin
                w_ma = w_hs;
                w_mb = MBW'(w_hs);
            end
            kbs_pkg::MS_S3: begin
                w_ma = w_hs2;
                w_mb = MBW'(w_hs);
            end
            kbs_pkg::MS_BL_IN: begin
                w_ma = MAW'(r_cp);
                w_mb = MBW'($signed(w_rec.tin[i_cmd.cmp]));
            end
            kbs_pkg::MS_BL_OUT: begin
                w_ma = MAW'(r_cn);
                w_mb = MBW'($signed(w_rec.tout[i_cmd.cmp]));
            end
            kbs_pkg::MS_H00: begin
                w_ma = w_h00;
                w_mb = MBW'($signed(r_ra.pos[i_cmd.cmp]));
            end
            kbs_pkg::MS_H10: begin
                w_ma = w_h10;
                w_mb = MBW'($signed(r_ra.blend[i_cmd.cmp]));
            end
            kbs_pkg::MS_H01: begin
                w_ma = w_h01;
                w_mb = MBW'($signed(r_rb.pos[i_cmd.cmp]));
            end
            kbs_pkg::MS_H11: begin
                w_ma = w_h11;
                w_mb = MBW'($signed(r_rb.blend[i_cmd.cmp]));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_sum  = r_acc + ACCW'(r_prod);
        w_sh16 = w_sum >>> 16;
        // saturate to 32 bits unless the top bits are all sign
        if ((w_sh16[ACCW-1:CRDW-1] == '0) || (w_sh16[ACCW-1:CRDW-1] == '1)) begin
            w_sat = w_sh16[CRDW-1:0];
        end else if (w_sh16[ACCW-1]) begin
            w_sat = $signed({1'b1, {(CRDW-1){1'b0}}});
        end else begin
            w_sat = $signed({1'b0, {(CRDW-1){1'b1}}});
        end
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = TANW'(r_v[c]) - TANW'($signed(r_rb.pos[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.act == kbs_pkg::DA_WR_NEW) begin
            r_count <= CW'(w_eff + CMPW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_act    <= i_action;
            r_idx    <= i_point_index;
            r_v[0]   <= i_x_value;
            r_v[1]   <= i_y_value;
            r_v[2]   <= i_z_value;
            r_tens   <= i_tension_in;
            r_bias   <= i_bias_in;
            r_param  <= i_param_in;
            r_status <= kbs_pkg::ST_OK;
            for (int c = 0; c < 3; c++) begin
                r_res[c] <= '0;
            end
        end

        if (i_cmd.mul != kbs_pkg::MS_NONE) begin
            r_prod <= w_ma * w_mb;
        end

        case (i_cmd.acc)
            kbs_pkg::AC_LOAD: r_acc <= ACCW'(r_prod);
            kbs_pkg::AC_ADD:  r_acc <= w_sum;
            default:          r_acc <= r_acc;
        endcase

        case (i_cmd.act)
            kbs_pkg::DA_CAP: begin
                if (i_cmd.sel) begin
                    r_rb <= kbs_pkg::t_rec'(w_rdata);
                end else begin
                    r_ra <= kbs_pkg::t_rec'(w_rdata);
                end
            end
            kbs_pkg::DA_NEW: begin
                for (int c = 0; c < 3; c++) begin
                    r_ra.pos[c]  <= r_v[c];
                    r_ra.tin[c]  <= w_diff[c];
                    r_ra.tout[c] <= '0;
                    r_rb.tout[c] <= w_diff[c];
                end
                r_ra.tens <= '0;
                r_ra.bias <= '0;
            end
            kbs_pkg::DA_NEW0: begin
                for (int c = 0; c < 3; c++) begin
                    r_ra.pos[c]  <= r_v[c];
                    r_ra.tin[c]  <= '0;
                    r_ra.tout[c] <= '0;
                end
                r_ra.tens <= '0;
                r_ra.bias <= '0;
            end
            kbs_pkg::DA_MOD: begin
                case (r_act)
                    kbs_pkg::ACT_SET_TB: begin
                        r_ra.tens <= r_tens;
                        r_ra.bias <= r_bias;
                    end
                    kbs_pkg::ACT_SET_IN: begin
                        for (int c = 0; c < 3; c++) begin
                            r_ra.tin[c] <= TANW'(r_v[c]);
                        end
                    end
                    default: begin
                        for (int c = 0; c < 3; c++) begin
                            r_ra.tout[c] <= TANW'(r_v[c]);
                        end
                    end
                endcase
            end
            kbs_pkg::DA_CP: r_cp <= COEFW'(r_prod >>> 15);
            kbs_pkg::DA_CN: r_cn <= COEFW'(r_prod >>> 15);
            kbs_pkg::DA_BLEND: begin
                if (i_cmd.sel) begin
                    r_rb.blend[i_cmd.cmp] <= BLDW'(w_sum >>> 14);
                end else begin
                    r_ra.blend[i_cmd.cmp] <= BLDW'(w_sum >>> 14);
                end
            end
            kbs_pkg::DA_S2: r_s2 <= r_prod[31:16];
            kbs_pkg::DA_S3: r_s3 <= r_prod[31:16];
            kbs_pkg::DA_RES: r_res[i_cmd.cmp] <= w_sat;
            kbs_pkg::DA_RES_POS: begin
                for (int c = 0; c < 3; c++) begin
                    r_res[c] <= $signed(r_ra.pos[c]);
                end
            end
            kbs_pkg::DA_ST_RANGE: r_status <= kbs_pkg::ST_RANGE;
            kbs_pkg::DA_ST_EMPTY: r_status <= kbs_pkg::ST_EMPTY;
            kbs_pkg::DA_PUSH: begin
                r_ox      <= r_res[0];
                r_oy      <= r_res[1];
                r_oz      <= r_res[2];
                r_ostatus <= r_status;
            end
            default: begin
                r_cp <= r_cp;
            end
        endcase
    end

    assign o_x_out  = r_ox;
    assign o_y_out  = r_oy;
    assign o_z_out  = r_oz;
    assign o_status = r_ostatus;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(MAX_POINTS))
        else $error("point count above table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == kbs_pkg::DA_WR_NEW) |=> (r_count != '0))
        else $error("append left the curve empty");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == kbs_pkg::DA_WR_IDX) |-> (w_idx < w_cnt))
        else $error("point update outside the curve");

endmodule

// File: src/kbs_ctrl.sv
module kbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kbs_pkg::t_dp_stat i_stat,
    output kbs_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE,
        S_DECODE,
        S_A_RDP,
        S_A_CAPP,
        S_A_NEW,
        S_A_NEW0,
        S_WR_PREV,
        S_WR_NEW,
        S_S_RD,
        S_S_CAP,
        S_S_MOD,
        S_WR_IDX,
        S_E_RDL,
        S_E_CAPL,
        S_E_POS,
        S_E_RD0,
        S_E_RD1,
        S_E_CAPB,
        S_E_SQW,
        S_E_CU,
        S_E_CUW,
        S_E_H0,
        S_E_H1,
        S_E_H2,
        S_E_H3,
        S_E_H4,
        S_RB_C1,
        S_RB_C2,
        S_RB_C3,
        S_RB_M0,
        S_RB_M1,
        S_RB_M2,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret,   n_ret;
    logic       r_sel,   n_sel;
    logic [1:0] r_cmp,   n_cmp;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_sel   = r_sel;
        n_cmp   = r_cmp;

        o_cmd.take = 1'b0;
        o_cmd.act  = kbs_pkg::DA_NONE;
        o_cmd.mul  = kbs_pkg::MS_NONE;
        o_cmd.acc  = kbs_pkg::AC_HOLD;
        o_cmd.rd   = kbs_pkg::RD_NONE;
        o_cmd.sel  = r_sel;
        o_cmd.cmp  = r_cmp;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.action)
                    kbs_pkg::ACT_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.act = kbs_pkg::DA_ST_RANGE;
                        end else if (i_stat.has_prev) begin
                            n_state = S_A_RDP;
                        end else begin
                            n_state = S_A_NEW0;
                        end
                    end
                    kbs_pkg::ACT_SET_TB, kbs_pkg::ACT_SET_IN, kbs_pkg::ACT_SET_OUT: begin
                        if (i_stat.bad_idx) begin
                            o_cmd.act = kbs_pkg::DA_ST_RANGE;
                        end else begin
                            n_state = S_S_RD;
                        end
                    end
                    kbs_pkg::ACT_EVAL: begin
                        if (i_stat.empty) begin
                            o_cmd.act = kbs_pkg::DA_ST_EMPTY;
                        end else if (i_stat.at_end) begin
                            n_state = S_E_RDL;
                        end else begin
                            n_state = S_E_RD0;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_A_RDP: begin
                o_cmd.rd = kbs_pkg::RD_PREV;
                n_state  = S_A_CAPP;
            end
            S_A_CAPP: begin
                o_cmd.act = kbs_pkg::DA_CAP;
                o_cmd.sel = 1'b1;
                n_state   = S_A_NEW;
            end
            S_A_NEW: begin
                o_cmd.act = kbs_pkg::DA_NEW;
                n_sel     = 1'b1;
                n_ret     = S_WR_PREV;
                n_state   = S_RB_C1;
            end
            S_A_NEW0: begin
                o_cmd.act = kbs_pkg::DA_NEW0;
                n_sel     = 1'b0;
                n_ret     = S_WR_NEW;
                n_state   = S_RB_C1;
            end
            S_WR_PREV: begin
                o_cmd.act = kbs_pkg::DA_WR_PREV;
                n_sel     = 1'b0;
                n_ret     = S_WR_NEW;
                n_state   = S_RB_C1;
            end
            S_WR_NEW: begin
                o_cmd.act = kbs_pkg::DA_WR_NEW;
                n_state   = S_DONE;
            end
            S_S_RD: begin
                o_cmd.rd = kbs_pkg::RD_IDX;
                n_state  = S_S_CAP;
            end
            S_S_CAP: begin
                o_cmd.act = kbs_pkg::DA_CAP;
                o_cmd.sel = 1'b0;
                n_state   = S_S_MOD;
            end
            S_S_MOD: begin
                o_cmd.act = kbs_pkg::DA_MOD;
                n_sel     = 1'b0;
                n_ret     = S_WR_IDX;
                n_state   = S_RB_C1;
            end
            S_WR_IDX: begin
                o_cmd.act = kbs_pkg::DA_WR_IDX;
                n_state   = S_DONE;
            end
            S_E_RDL: begin
                o_cmd.rd = kbs_pkg::RD_LAST;
                n_state  = S_E_CAPL;
            end
            S_E_CAPL: begin
                o_cmd.act = kbs_pkg::DA_CAP;
                o_cmd.sel = 1'b0;
                n_state   = S_E_POS;
            end
            S_E_POS: begin
                o_cmd.act = kbs_pkg::DA_RES_POS;
                n_state   = S_DONE;
            end
            S_E_RD0: begin
                o_cmd.rd = kbs_pkg::RD_I0;
                n_state  = S_E_RD1;
            end
            S_E_RD1: begin
                // second read issued while the first word is captured
                o_cmd.rd  = kbs_pkg::RD_I1;
                o_cmd.act = kbs_pkg::DA_CAP;
                o_cmd.sel = 1'b0;
                n_state   = S_E_CAPB;
            end
            S_E_CAPB: begin
                o_cmd.act = kbs_pkg::DA_CAP;
                o_cmd.sel = 1'b1;
                o_cmd.mul = kbs_pkg::MS_S2;
                n_state   = S_E_SQW;
            end
            S_E_SQW: begin
                o_cmd.act = kbs_pkg::DA_S2;
                n_state   = S_E_CU;
            end
            S_E_CU: begin
                o_cmd.mul = kbs_pkg::MS_S3;
                n_state   = S_E_CUW;
            end
            S_E_CUW: begin
                o_cmd.act = kbs_pkg::DA_S3;
                n_cmp     = 2'd0;
                n_state   = S_E_H0;
            end
            S_E_H0: begin
                o_cmd.mul = kbs_pkg::MS_H00;
                n_state   = S_E_H1;
            end
            S_E_H1: begin
                o_cmd.mul = kbs_pkg::MS_H10;
                o_cmd.acc = kbs_pkg::AC_LOAD;
                n_state   = S_E_H2;
            end
            S_E_H2: begin
                o_cmd.mul = kbs_pkg::MS_H01;
                o_cmd.acc = kbs_pkg::AC_ADD;
                n_state   = S_E_H3;
            end
            S_E_H3: begin
                o_cmd.mul = kbs_pkg::MS_H11;
                o_cmd.acc = kbs_pkg::AC_ADD;
                n_state   = S_E_H4;
            end
            S_E_H4: begin
                o_cmd.act = kbs_pkg::DA_RES;
                if (r_cmp == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_cmp   = r_cmp + 2'd1;
                    n_state = S_E_H0;
                end
            end
            // re-blend of the record picked by r_sel, then return to r_ret
            S_RB_C1: begin
                o_cmd.mul = kbs_pkg::MS_CF_P;
                n_state   = S_RB_C2;
            end
            S_RB_C2: begin
                o_cmd.mul = kbs_pkg::MS_CF_N;
                o_cmd.act = kbs_pkg::DA_CP;
                n_state   = S_RB_C3;
            end
            S_RB_C3: begin
                o_cmd.act = kbs_pkg::DA_CN;
                n_cmp     = 2'd0;
                n_state   = S_RB_M0;
            end
            S_RB_M0: begin
                o_cmd.mul = kbs_pkg::MS_BL_IN;
                n_state   = S_RB_M1;
            end
            S_RB_M1: begin
                o_cmd.mul = kbs_pkg::MS_BL_OUT;
                o_cmd.acc = kbs_pkg::AC_LOAD;
                n_state   = S_RB_M2;
            end
            S_RB_M2: begin
                o_cmd.act = kbs_pkg::DA_BLEND;
                if (r_cmp == 2'd2) begin
                    n_state = r_ret;
                end else begin
                    n_cmp   = r_cmp + 2'd1;
                    n_state = S_RB_M0;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.act = kbs_pkg::DA_PUSH;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.act == kbs_pkg::DA_PUSH) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_sel    <= 1'b0;
            r_cmp    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_sel    <= n_sel;
            r_cmp    <= n_cmp;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    a_take_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp != 2'd3)
        else $error("component counter out of range");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished word not moved to output");

endmodule

// File: src/kochanek_bartels_spline_eval_core.sv
// Kochanek-Bartels spline evaluator over up to MAX_POINTS 3D control points on
// integer knots, one input word at a time. All control point data sits in one
// record memory with one write and one read port, and every multiply goes
// through one shared 20x38 multiply-accumulate. An append re-blends two points
// (one for the first point); setting tension, bias or a tangent re-blends one;
// an interior evaluate sums four Hermite terms per axis, and an evaluate at or
// beyond the last knot returns the last knot's position. A result waits in an
// output register, so the next word is taken while it is pending.
module kochanek_bartels_spline_eval_core #(
    parameter int MAX_POINTS = kbs_pkg::MAX_POINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbs_in_if.sink     i_in,
    kbs_out_if.source  o_out
);

    kbs_pkg::t_ctl_cmd w_cmd;
    kbs_pkg::t_dp_stat w_stat;
    logic              w_ready;
    logic              w_ovalid;

    kbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_ready),
        .o_out_valid (w_ovalid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    kbs_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_in.action),
        .i_point_index (i_in.point_index),
        .i_x_value     (i_in.x_value),
        .i_y_value     (i_in.y_value),
        .i_z_value     (i_in.z_value),
        .i_tension_in  (i_in.tension_in),
        .i_bias_in     (i_in.bias_in),
        .i_param_in    (i_in.param_in),
        .o_x_out       (o_out.x_out),
        .o_y_out       (o_out.y_out),
        .o_z_out       (o_out.z_out),
        .o_status      (o_out.status)
    );

    assign i_in.ready  = w_ready;
    assign o_out.valid = w_ovalid;

endmodule

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kbs_pkg::*;

    localparam int NPTS = 256;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]         action;
        logic [7:0]         idx;
        logic signed [31:0] x, y, z;
        logic signed [15:0] tens, bias;
        logic [23:0]        param;
        bit                 typed;
        logic signed [31:0] ex, ey, ez;
        t_status            est;
    } word_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [1:0]         st;
    } point_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kbs_in_if  in_bus();
    kbs_out_if out_bus();

    kochanek_bartels_spline_eval_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow curve state
    longint knot_pos [NPTS][3];
    longint tan_in   [NPTS][3];
    longint tan_out  [NPTS][3];
    longint tan_bl   [NPTS][3];
    longint knot_tens[NPTS];
    longint knot_bias[NPTS];
    int     knot_count = 0;

    point_res_t pending_points[$];
    int errors = 0;
    int src_idle = 0;
    int rcv_idle = 0;
    int hold_req = 0;
    int hold_cnt = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void reblend(int i);
        longint onemt, cp, cn;
        onemt = 16384 - knot_tens[i];
        cp = (onemt * (16384 + knot_bias[i])) >>> 15;
        cn = (onemt * (16384 - knot_bias[i])) >>> 15;
        for (int c = 0; c < 3; c++)
            tan_bl[i][c] = (cp * tan_in[i][c] + cn * tan_out[i][c]) >>> 14;
    endfunction

    function automatic point_res_t spline_step(word_t w);
        point_res_t r;
        longint v[3];
        int n, last, i0;
        longint s, s2, s3, h00, h10, h01, h11, acc;
        r.x = 0; r.y = 0; r.z = 0; r.st = ST_OK;
        v[0] = w.x; v[1] = w.y; v[2] = w.z;
        if (w.action == ACT_APPEND) begin
            if (w.idx == 0) knot_count = 0;
            if (knot_count >= NPTS) begin
                r.st = ST_RANGE;
            end else begin
                n = knot_count;
                for (int c = 0; c < 3; c++) knot_pos[n][c] = v[c];
                knot_tens[n] = 0;
                knot_bias[n] = 0;
                for (int c = 0; c < 3; c++) begin
                    tan_in[n][c] = (n > 0) ? v[c] - knot_pos[n-1][c] : 0;
                    if (n > 0) tan_out[n-1][c] = v[c] - knot_pos[n-1][c];
                    tan_out[n][c] = 0;
                end
                if (n > 0) reblend(n - 1);
                reblend(n);
                knot_count = n + 1;
            end
        end else if (w.action == ACT_SET_TB || w.action == ACT_SET_IN ||
                     w.action == ACT_SET_OUT) begin
            if (w.idx >= knot_count) begin
                r.st = ST_RANGE;
            end else begin
                if (w.action == ACT_SET_TB) begin
                    knot_tens[w.idx] = w.tens;
                    knot_bias[w.idx] = w.bias;
                end else if (w.action == ACT_SET_IN) begin
                    for (int c = 0; c < 3; c++) tan_in[w.idx][c] = v[c];
                end else begin
                    for (int c = 0; c < 3; c++) tan_out[w.idx][c] = v[c];
                end
                reblend(w.idx);
            end
        end else if (w.action == ACT_EVAL) begin
            if (knot_count == 0) begin
                r.st = ST_EMPTY;
            end else begin
                last = knot_count - 1;
                i0 = w.param[23:16];
                if (i0 >= last) begin
                    r.x = 32'(knot_pos[last][0]);
                    r.y = 32'(knot_pos[last][1]);
                    r.z = 32'(knot_pos[last][2]);
                end else begin
                    s = w.param[15:0];
                    s2 = (s * s) >>> 16;
                    s3 = (s2 * s) >>> 16;
                    h00 = 2 * s3 - 3 * s2 + 65536;
                    h10 = s3 - 2 * s2 + s;
                    h01 = -2 * s3 + 3 * s2;
                    h11 = s3 - s2;
                    for (int c = 0; c < 3; c++) begin
                        acc = h00 * knot_pos[i0][c] + h10 * tan_bl[i0][c]
                            + h01 * knot_pos[i0+1][c] + h11 * tan_bl[i0+1][c];
                        v[c] = sat32(acc >>> 16);
                    end
                    r.x = 32'(v[0]); r.y = 32'(v[1]); r.z = 32'(v[2]);
                end
            end
        end
        return r;
    endfunction

    task automatic send_word(word_t w);
        point_res_t r;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < src_idle) begin
                in_bus.valid <= 1'b0;
            end else begin
                in_bus.valid       <= 1'b1;
                in_bus.action      <= w.action;
                in_bus.point_index <= w.idx;
                in_bus.x_value     <= w.x;
                in_bus.y_value     <= w.y;
                in_bus.z_value     <= w.z;
                in_bus.tension_in  <= w.tens;
                in_bus.bias_in     <= w.bias;
                in_bus.param_in    <= w.param;
                break;
            end
        end
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        r = spline_step(w);
        if (w.typed) begin
            r.x = w.ex; r.y = w.ey; r.z = w.ez; r.st = w.est;
        end
        pending_points.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            2:       return ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic word_t blank(logic [2:0] a, logic [7:0] i);
        word_t w;
        w.action = a; w.idx = i;
        w.x = rand_coord(); w.y = rand_coord(); w.z = rand_coord();
        w.tens = 16'($urandom); w.bias = 16'($urandom); w.param = 24'($urandom);
        w.typed = 1'b0; w.ex = 0; w.ey = 0; w.ez = 0; w.est = ST_OK;
        return w;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int k;
        k = $urandom_range(0, 99);
        if (k < 28) begin
            w = blank(ACT_APPEND, (knot_count > 40 || $urandom_range(0, 30) == 0) ?
                      8'd0 : 8'($urandom_range(1, 255)));
        end else if (k < 42) begin
            w = blank(ACT_SET_TB, 8'($urandom_range(0, knot_count)));
            if ($urandom_range(0, 1)) begin
                w.tens = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
                w.bias = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            end
        end else if (k < 60) begin
            w = blank($urandom_range(0, 1) ? ACT_SET_IN : ACT_SET_OUT,
                      8'($urandom_range(0, knot_count)));
        end else if (k < 95) begin
            w = blank(ACT_EVAL, 8'($urandom));
            if ($urandom_range(0, 4) != 0 && knot_count > 0)
                w.param = 24'($urandom_range(0, knot_count * 65536 - 1));
        end else begin
            w = blank(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 8'($urandom));
        end
        // stray indices now and then
        if (w.action != ACT_APPEND && $urandom_range(0, 9) == 0) w.idx = 8'($urandom);
        return w;
    endfunction

    // receiver: random ready, plus a long hold-off on request
    initial out_bus.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= i_rst_n && ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        point_res_t e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected word: x %h y %h z %h status %0d",
                       out_bus.x_out, out_bus.y_out, out_bus.z_out, out_bus.status);
                errors++;
            end else begin
                e = pending_points.pop_front();
                if (out_bus.x_out !== e.x) begin
                    $error("x_out expected %h actual %h", e.x, out_bus.x_out);
                    errors++;
                end
                if (out_bus.y_out !== e.y) begin
                    $error("y_out expected %h actual %h", e.y, out_bus.y_out);
                    errors++;
                end
                if (out_bus.z_out !== e.z) begin
                    $error("z_out expected %h actual %h", e.z, out_bus.z_out);
                    errors++;
                end
                if (out_bus.status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, out_bus.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        word_t dir[$];
        word_t w;

        in_bus.valid = 1'b0;
        in_bus.action = ACT_APPEND;
        in_bus.point_index = '0;
        in_bus.x_value = '0;
        in_bus.y_value = '0;
        in_bus.z_value = '0;
        in_bus.tension_in = '0;
        in_bus.bias_in = '0;
        in_bus.param_in = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty curve, bad index, spare codes, extremes
        w = blank(ACT_EVAL, 0);      w.typed = 1; w.est = ST_EMPTY; dir.push_back(w);
        w = blank(ACT_SET_TB, 0);    w.typed = 1; w.est = ST_RANGE; dir.push_back(w);
        w = blank(ACT_SPARE_LO, 3);  w.typed = 1; dir.push_back(w);
        w = blank(ACT_SPARE_HI, 0);  w.typed = 1; dir.push_back(w);
        w = blank(ACT_APPEND, 0);
        w.x = 32'sh7fff_ffff; w.y = 32'sh7fff_ffff; w.z = 32'sh7fff_ffff;
        w.typed = 1; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'hff_ffff; w.typed = 1;
        w.ex = 32'sh7fff_ffff; w.ey = 32'sh7fff_ffff; w.ez = 32'sh7fff_ffff;
        dir.push_back(w);
        // append with a nonzero index lands at the end anyway
        w = blank(ACT_APPEND, 8'd77);
        w.x = 32'sh8000_0000; w.y = 32'sh8000_0000; w.z = 32'sh8000_0000;
        w.typed = 1; dir.push_back(w);
        w = blank(ACT_SET_TB, 0); w.tens = 16'sh8000; w.bias = 16'sh7fff; dir.push_back(w);
        w = blank(ACT_SET_TB, 1); w.tens = 16'sh7fff; w.bias = 16'sh8000; dir.push_back(w);
        w = blank(ACT_SET_IN, 0);
        w.x = 32'sh7fff_ffff; w.y = 32'sh8000_0000; w.z = 32'sh7fff_ffff; dir.push_back(w);
        w = blank(ACT_SET_OUT, 1);
        w.x = 32'sh8000_0000; w.y = 32'sh7fff_ffff; w.z = 32'sh8000_0000; dir.push_back(w);
        w = blank(ACT_SET_IN, 2); w.typed = 1; w.est = ST_RANGE; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h00_0000; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h00_8000; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h00_ffff; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h01_0000; w.typed = 1;
        w.ex = 32'sh8000_0000; w.ey = 32'sh8000_0000; w.ez = 32'sh8000_0000;
        dir.push_back(w);
        w = blank(ACT_APPEND, 5); dir.push_back(w);
        w = blank(ACT_SET_TB, 1); w.tens = 16'sd0; w.bias = 16'sd0; dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h01_8000; dir.push_back(w);
        w = blank(ACT_SET_OUT, 8'hff); w.typed = 1; w.est = ST_RANGE; dir.push_back(w);
        w = blank(ACT_APPEND, 0); dir.push_back(w);
        w = blank(ACT_EVAL, 0); w.param = 24'h12_3456; dir.push_back(w);
        foreach (dir[i]) send_word(dir[i]);

        // phase 1: receiver mostly stalled, with one long hold-off up front
        src_idle = 30; rcv_idle = 78;
        hold_req = 400;
        repeat (500) send_word(rand_word());

        src_idle = 78; rcv_idle = 30;
        repeat (500) send_word(rand_word());

        // phase 3: fill the table to the brim, then one append too many
        src_idle = 0; rcv_idle = 0;
        send_word(blank(ACT_APPEND, 0));
        repeat (NPTS - 1) send_word(blank(ACT_APPEND, 8'($urandom_range(1, 255))));
        w = blank(ACT_APPEND, 8'd9); w.typed = 1; w.est = ST_RANGE; send_word(w);
        repeat (40) send_word(rand_word());
        w = blank(ACT_APPEND, 0); send_word(w);
        repeat (200) send_word(rand_word());

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
